@@ rtl/lts_pkg.sv @@
// Shared types, constants and register indexes for the landing tracker supervisor.
package lts_pkg;

  localparam int CENTRE_TICKS_NEEDED = 30;
  localparam int VISION_TICKS_LIMIT  = 30;
  localparam int GAIN_FRACTION_BITS  = 14;

  localparam int PROD_W = 34;

  localparam logic [15:0] CLIMB_RATE = 16'd200;
  localparam logic [5:0]  TICK_MAX   = 6'd63;

  localparam logic [1:0] MODE_TRACK  = 2'd0;
  localparam logic [1:0] MODE_DISARM = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_CLIMB  = 2'd1;
  localparam logic [1:0] KIND_DISARM = 2'd2;

  localparam logic [3:0] REG_GAIN_XY         = 4'd0;
  localparam logic [3:0] REG_GAIN_Z          = 4'd1;
  localparam logic [3:0] REG_VEL_LIMIT_XY    = 4'd2;
  localparam logic [3:0] REG_VEL_LIMIT_Z     = 4'd3;
  localparam logic [3:0] REG_DEAD_BAND       = 4'd4;
  localparam logic [3:0] REG_LAND_RADIUS     = 4'd5;
  localparam logic [3:0] REG_LAND_HEIGHT_MAX = 4'd6;
  localparam logic [3:0] REG_HOVER_HEIGHT    = 4'd7;

  typedef struct packed {
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    logic signed [15:0] rel_z;
    logic               target_seen;
  } lts_in_t;

  typedef struct packed {
    logic        [1:0]  command_kind;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic        [15:0] seq_number;
    logic        [1:0]  next_mode;
  } lts_out_t;

  typedef struct packed {
    logic        [15:0] gain_xy;
    logic        [15:0] gain_z;
    logic        [14:0] vel_limit_xy;
    logic        [14:0] vel_limit_z;
    logic        [14:0] dead_band;
    logic        [14:0] land_radius;
    logic signed [15:0] land_height_max;
    logic signed [15:0] hover_height;
  } lts_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [1:0]  next_mode;
  } lts_ctl_t;

endpackage

@@ rtl/landing_tracker_supervisor_unit.sv @@
// Landing tracker supervisor: input register, single-pass control logic, result register.
// Each item goes through the input register into the result register, which drives out_valid.
// Throughput: one item per cycle while not stalled; each passes the three axis multipliers once.
// One more input item is taken while a finished result waits on a stalled output; then hold.
// Reset (rst_n low, synchronous): pipeline emptied, mode track, counters zero,
// sequence one, configuration registers back to their defaults.
module landing_tracker_supervisor_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lts_pkg::lts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lts_pkg::lts_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  lts_pkg::lts_cfg_t  cfg;
  lts_pkg::lts_ctl_t  ctl;
  lts_pkg::lts_in_t   s_data_r;
  lts_pkg::lts_out_t  out_data_r, out_data_nxt;
  logic               s_valid_r, s_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               adv;
  logic               in_take;
  logic signed [16:0] err_x, err_y, err_z;
  logic signed [15:0] vx, vy, vz;

  lts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the held item whenever the result register is free or being drained
  assign adv      = s_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign s_valid_nxt   = in_take || (s_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  assign err_x = 17'(s_data_r.rel_x);
  assign err_y = 17'(s_data_r.rel_y);
  assign err_z = $signed({s_data_r.rel_z[15], s_data_r.rel_z})
               - $signed({cfg.hover_height[15], cfg.hover_height});

  lts_axis_ctrl u_axis_x (
    .gain   (cfg.gain_xy),
    .err    (err_x),
    .negate (1'b0),
    .lim    (cfg.vel_limit_xy),
    .band   (cfg.dead_band),
    .vel    (vx)
  );

  lts_axis_ctrl u_axis_y (
    .gain   (cfg.gain_xy),
    .err    (err_y),
    .negate (1'b1),
    .lim    (cfg.vel_limit_xy),
    .band   (cfg.dead_band),
    .vel    (vy)
  );

  lts_axis_ctrl u_axis_z (
    .gain   (cfg.gain_z),
    .err    (err_z),
    .negate (1'b1),
    .lim    (cfg.vel_limit_z),
    .band   (cfg.dead_band),
    .vel    (vz)
  );

  lts_supervisor u_sup (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .rel_x           (s_data_r.rel_x),
    .rel_y           (s_data_r.rel_y),
    .rel_z           (s_data_r.rel_z),
    .target_seen     (s_data_r.target_seen),
    .land_radius     (cfg.land_radius),
    .land_height_max (cfg.land_height_max),
    .ctl             (ctl)
  );

  always_comb begin
    out_data_nxt.command_kind = ctl.kind;
    out_data_nxt.seq_number   = ctl.seq;
    out_data_nxt.next_mode    = ctl.next_mode;
    out_data_nxt.vel_x        = '0;
    out_data_nxt.vel_y        = '0;
    out_data_nxt.vel_z        = '0;
    case (ctl.kind)
      lts_pkg::KIND_MOVE: begin
        out_data_nxt.vel_x = vx;
        out_data_nxt.vel_y = vy;
        out_data_nxt.vel_z = vz;
      end
      lts_pkg::KIND_CLIMB: begin
        out_data_nxt.vel_z = $signed(lts_pkg::CLIMB_RATE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/lts_cfg_regs.sv @@
// Configuration register file with reset defaults.
module lts_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output lts_pkg::lts_cfg_t cfg
);

  lts_pkg::lts_cfg_t cfg_r;
  lts_pkg::lts_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lts_pkg::REG_GAIN_XY:         cfg_nxt.gain_xy         = cfg_data;
        lts_pkg::REG_GAIN_Z:          cfg_nxt.gain_z          = cfg_data;
        lts_pkg::REG_VEL_LIMIT_XY:    cfg_nxt.vel_limit_xy    = cfg_data[14:0];
        lts_pkg::REG_VEL_LIMIT_Z:     cfg_nxt.vel_limit_z     = cfg_data[14:0];
        lts_pkg::REG_DEAD_BAND:       cfg_nxt.dead_band       = cfg_data[14:0];
        lts_pkg::REG_LAND_RADIUS:     cfg_nxt.land_radius     = cfg_data[14:0];
        lts_pkg::REG_LAND_HEIGHT_MAX: cfg_nxt.land_height_max = $signed(cfg_data);
        lts_pkg::REG_HOVER_HEIGHT:    cfg_nxt.hover_height    = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_xy         <= 16'd4915;
      cfg_r.gain_z          <= 16'd4915;
      cfg_r.vel_limit_xy    <= 15'd1000;
      cfg_r.vel_limit_z     <= 15'd1000;
      cfg_r.dead_band       <= 15'd20;
      cfg_r.land_radius     <= 15'd200;
      cfg_r.land_height_max <= 16'sd300;
      cfg_r.hover_height    <= 16'sd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/lts_axis_ctrl.sv @@
// One proportional axis: gain product, rounding, deadband and symmetric limit.
module lts_axis_ctrl (
  input  logic        [15:0] gain,
  input  logic signed [16:0] err,
  input  logic               negate,
  input  logic        [14:0] lim,
  input  logic        [14:0] band,
  output logic signed [15:0] vel
);

  localparam int PW = lts_pkg::PROD_W;

  logic signed [16:0]   gain_s;
  logic signed [PW-1:0] prod;
  logic                 prod_neg;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        rnd;
  logic [PW-1:0]        quo;
  logic [14:0]          clip_mag;
  logic                 out_neg;

  assign gain_s   = $signed({1'b0, gain});
  assign prod     = gain_s * err;
  assign prod_neg = prod[PW-1];
  assign mag      = prod_neg ? $unsigned(-prod) : $unsigned(prod);
  // round half away from zero on the magnitude
  assign rnd      = mag + (PW'(1) << (lts_pkg::GAIN_FRACTION_BITS - 1));
  assign quo      = rnd >> lts_pkg::GAIN_FRACTION_BITS;
  assign out_neg  = prod_neg ^ negate;

  // deadband takes precedence over the limit
  always_comb begin
    if (quo < PW'(band)) begin
      clip_mag = '0;
    end else if (quo > PW'(lim)) begin
      clip_mag = lim;
    end else begin
      clip_mag = quo[14:0];
    end
  end

  assign vel = out_neg ? $signed(-{1'b0, clip_mag}) : $signed({1'b0, clip_mag});

endmodule

@@ rtl/lts_supervisor.sv @@
// Mode sequencer: track, search and disarm, with tick counters and sequence number.
module lts_supervisor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic signed [15:0] rel_x,
  input  logic signed [15:0] rel_y,
  input  logic signed [15:0] rel_z,
  input  logic               target_seen,
  input  logic        [14:0] land_radius,
  input  logic signed [15:0] land_height_max,
  output lts_pkg::lts_ctl_t  ctl
);

  logic [1:0]  mode_r,    mode_nxt;
  logic [5:0]  centred_r, centred_nxt;
  logic [5:0]  vision_r,  vision_nxt;
  logic [15:0] seq_r,     seq_nxt;

  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic [32:0]        dist_sq;
  logic [29:0]        rad_sq;
  logic               in_radius;
  logic               low;
  logic [5:0]         vision_bump;

  assign sq_x      = rel_x * rel_x;
  assign sq_y      = rel_y * rel_y;
  assign dist_sq   = {1'b0, $unsigned(sq_x)} + {1'b0, $unsigned(sq_y)};
  assign rad_sq    = land_radius * land_radius;
  assign in_radius = dist_sq < 33'(rad_sq);
  assign low       = rel_z <= land_height_max;

  always_comb begin
    mode_nxt    = mode_r;
    centred_nxt = centred_r;
    vision_nxt  = vision_r;
    seq_nxt     = seq_r;
    vision_bump = (vision_r < lts_pkg::TICK_MAX) ? vision_r + 6'd1 : lts_pkg::TICK_MAX;
    ctl.kind      = lts_pkg::KIND_DISARM;
    ctl.seq       = seq_r - 16'd1;
    ctl.next_mode = lts_pkg::MODE_DISARM;
    case (mode_r)
      lts_pkg::MODE_TRACK: begin
        ctl.kind = lts_pkg::KIND_MOVE;
        ctl.seq  = seq_r;
        seq_nxt  = seq_r + 16'd1;
        if (in_radius && target_seen) begin
          centred_nxt = (centred_r < lts_pkg::TICK_MAX) ? centred_r + 6'd1
                                                        : lts_pkg::TICK_MAX;
        end else begin
          centred_nxt = '0;
        end
        if (in_radius && low && centred_nxt > 6'(lts_pkg::CENTRE_TICKS_NEEDED)) begin
          mode_nxt = lts_pkg::MODE_DISARM;
        end else begin
          mode_nxt = lts_pkg::MODE_TRACK;
        end
        vision_nxt = target_seen ? 6'd0 : vision_bump;
        if (vision_nxt > 6'(lts_pkg::VISION_TICKS_LIMIT)) begin
          vision_nxt = '0;
          mode_nxt   = lts_pkg::MODE_SEARCH;
        end
        ctl.next_mode = mode_nxt;
      end
      lts_pkg::MODE_SEARCH: begin
        ctl.kind   = lts_pkg::KIND_CLIMB;
        ctl.seq    = seq_r;
        seq_nxt    = seq_r + 16'd1;
        vision_nxt = target_seen ? vision_bump : 6'd0;
        if (vision_nxt > 6'(lts_pkg::VISION_TICKS_LIMIT)) begin
          vision_nxt = '0;
          mode_nxt   = lts_pkg::MODE_TRACK;
        end
        ctl.next_mode = mode_nxt;
      end
      default: begin
        // disarm holds until reset
        mode_nxt = lts_pkg::MODE_DISARM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lts_pkg::MODE_TRACK;
      centred_r <= '0;
      vision_r  <= '0;
      seq_r     <= 16'd1;
    end else if (adv) begin
      mode_r    <= mode_nxt;
      centred_r <= centred_nxt;
      vision_r  <= vision_nxt;
      seq_r     <= seq_nxt;
    end
  end

  a_disarm_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == lts_pkg::MODE_DISARM |=> mode_r == lts_pkg::MODE_DISARM)
    else $error("disarm mode left without reset");

  a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(seq_r) && $stable(mode_r) && $stable(vision_r))
    else $error("state moved without a transfer");

  a_disarm_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    adv && mode_r == lts_pkg::MODE_DISARM |=> $stable(seq_r))
    else $error("disarm consumed a sequence number");

  a_search_climb: assert property (@(posedge clk) disable iff (!rst_n)
    adv && mode_r == lts_pkg::MODE_SEARCH |-> ctl.kind == lts_pkg::KIND_CLIMB && ctl.seq == seq_r)
    else $error("search tick issued wrong command");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the landing tracker supervisor: random ticks, shadow predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lts_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SHOWN_MAX   = 30;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  lts_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lts_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // shadow of the supervisor state and its registers
  logic [1:0]  sup_mode    = MODE_TRACK;
  int          centred_cnt = 0;
  int          vision_cnt  = 0;
  logic [15:0] seq_next    = 16'd1;
  int set_gain_xy = 4915;
  int set_gain_z  = 4915;
  int set_lim_xy  = 1000;
  int set_lim_z   = 1000;
  int set_band    = 20;
  int set_radius  = 200;
  int set_land_h  = 300;
  int set_hover   = 300;

  lts_in_t  pending_ticks[$];
  lts_out_t expected_cmds[$];
  int ticks_queued = 0;
  int ticks_taken  = 0;
  int fail_cnt     = 0;
  int shown_cnt    = 0;
  int cycle_cnt    = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int style_left   = 0;
  int centre_run   = 0;
  bit guard_on     = 1'b1;
  stall_style_e stall_style = STALL_NONE;

  landing_tracker_supervisor_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clip16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // gain has GAIN_FRACTION_BITS fraction bits; round half away from zero
  function automatic longint scale_vel(int gain, longint val, bit negate);
    longint p, mag, q;
    bit     neg;
    p   = longint'(gain) * val;
    neg = p < 0;
    mag = neg ? -p : p;
    q   = (mag + (longint'(1) << (GAIN_FRACTION_BITS - 1))) >> GAIN_FRACTION_BITS;
    return (neg != negate) ? -q : q;
  endfunction

  // deadband first, then the symmetric limit
  function automatic longint clamp_vel(longint v, int lim, int band);
    longint mag;
    mag = (v < 0) ? -v : v;
    if (mag < band) return 0;
    if (mag > lim) return (v > 0) ? longint'(lim) : -longint'(lim);
    return v;
  endfunction

  function automatic int bump_tick(int t);
    return (t < int'(TICK_MAX)) ? t + 1 : int'(TICK_MAX);
  endfunction

  function automatic lts_out_t step_supervisor(lts_in_t t);
    lts_out_t r;
    longint   x, y, z, rr;
    bit       in_radius, centred, low;
    r = '0;
    x = longint'(t.rel_x);
    y = longint'(t.rel_y);
    z = longint'(t.rel_z);
    r.next_mode = sup_mode;
    case (sup_mode)
      MODE_TRACK: begin
        rr = longint'(set_radius);
        in_radius = (x * x + y * y) < (rr * rr);
        r.command_kind = KIND_MOVE;
        r.seq_number = seq_next;
        seq_next = seq_next + 16'd1;
        r.vel_x = 16'(clamp_vel(scale_vel(set_gain_xy, x, 1'b0), set_lim_xy, set_band));
        r.vel_y = 16'(clamp_vel(scale_vel(set_gain_xy, y, 1'b1), set_lim_xy, set_band));
        r.vel_z = 16'(clamp_vel(scale_vel(set_gain_z, z - set_hover, 1'b1), set_lim_z,
                                set_band));
        centred_cnt = (in_radius && t.target_seen) ? bump_tick(centred_cnt) : 0;
        centred = in_radius && (centred_cnt > CENTRE_TICKS_NEEDED);
        low = z <= set_land_h;
        r.next_mode = (centred && low) ? MODE_DISARM : MODE_TRACK;
        vision_cnt = t.target_seen ? 0 : bump_tick(vision_cnt);
        if (vision_cnt > VISION_TICKS_LIMIT) begin
          vision_cnt = 0;
          r.next_mode = MODE_SEARCH;
        end
      end
      MODE_SEARCH: begin
        r.command_kind = KIND_CLIMB;
        r.vel_z = CLIMB_RATE;
        r.seq_number = seq_next;
        seq_next = seq_next + 16'd1;
        vision_cnt = t.target_seen ? bump_tick(vision_cnt) : 0;
        if (vision_cnt > VISION_TICKS_LIMIT) begin
          vision_cnt = 0;
          r.next_mode = MODE_TRACK;
        end
      end
      default: begin
        // disarm repeats the last number issued
        r.command_kind = KIND_DISARM;
        r.seq_number = seq_next - 16'd1;
        r.next_mode = MODE_DISARM;
      end
    endcase
    sup_mode = r.next_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [16:0] want_v,
                             input logic signed [16:0] got_v);
    if (got_v !== want_v) begin
      fail_cnt++;
      if (shown_cnt < SHOWN_MAX) begin
        shown_cnt++;
        $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      end
    end
  endtask

  // input side: bursts of transfers with random gaps
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_cmds.push_back(step_supervisor(in_data));
        ticks_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          in_data <= pending_ticks.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each transfer, stall on a pattern of its own
  always @(posedge clk) begin : monitor
    lts_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          fail_cnt++;
          if (shown_cnt < SHOWN_MAX) begin
            shown_cnt++;
            $display("%0t: result expected none got %h", $time, out_data);
          end
        end else begin
          want = expected_cmds.pop_front();
          check_field("command_kind", want.command_kind, out_data.command_kind);
          check_field("vel_x", want.vel_x, out_data.vel_x);
          check_field("vel_y", want.vel_y, out_data.vel_y);
          check_field("vel_z", want.vel_z, out_data.vel_z);
          check_field("seq_number", want.seq_number, out_data.seq_number);
          check_field("next_mode", want.next_mode, out_data.next_mode);
        end
      end
      if (style_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(16, 160);
      end else begin
        style_left--;
      end
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= (cycle_cnt % 3 == 0);
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_XY:         set_gain_xy = int'(val);
      REG_GAIN_Z:          set_gain_z  = int'(val);
      REG_VEL_LIMIT_XY:    set_lim_xy  = int'(val[14:0]);
      REG_VEL_LIMIT_Z:     set_lim_z   = int'(val[14:0]);
      REG_DEAD_BAND:       set_band    = int'(val[14:0]);
      REG_LAND_RADIUS:     set_radius  = int'(val[14:0]);
      REG_LAND_HEIGHT_MAX: set_land_h  = int'($signed(val));
      REG_HOVER_HEIGHT:    set_hover   = int'($signed(val));
      default: ;
    endcase
  endtask

  // the top bit of the 15-bit registers is random and must be dropped
  task automatic program_set(input lts_cfg_t c);
    write_reg(REG_GAIN_XY, c.gain_xy);
    write_reg(REG_GAIN_Z, c.gain_z);
    write_reg(REG_VEL_LIMIT_XY, {1'($urandom), c.vel_limit_xy});
    write_reg(REG_VEL_LIMIT_Z, {1'($urandom), c.vel_limit_z});
    write_reg(REG_DEAD_BAND, {1'($urandom), c.dead_band});
    write_reg(REG_LAND_RADIUS, {1'($urandom), c.land_radius});
    write_reg(REG_LAND_HEIGHT_MAX, c.land_height_max);
    write_reg(REG_HOVER_HEIGHT, c.hover_height);
    write_reg(4'(REG_HOVER_HEIGHT + 1 + $urandom_range(0, 7)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (ticks_taken != ticks_queued || expected_cmds.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // keep the centred run from reaching a landing unless the guard is off
  task automatic push_tick(input int x, input int y, input int z, input bit seen);
    lts_in_t t;
    longint  dx, dy, r;
    bit      in_radius;
    x = clip16(x);
    y = clip16(y);
    z = clip16(z);
    dx = longint'(x);
    dy = longint'(y);
    r = longint'(set_radius);
    in_radius = (dx * dx + dy * dy) < (r * r);
    if (in_radius && seen) centre_run++;
    else centre_run = 0;
    if (guard_on && centre_run > CENTRE_TICKS_NEEDED && z <= set_land_h) begin
      if (set_land_h < 32767) begin
        z = set_land_h + 1 + int'($urandom_range(0, 32766 - set_land_h));
      end else begin
        seen = 1'b0;
        centre_run = 0;
      end
    end
    t.rel_x = 16'(x);
    t.rel_y = 16'(y);
    t.rel_z = 16'(z);
    t.target_seen = seen;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  function automatic int near(int span);
    return clip16(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int edge_val(int base, int lim);
    case ($urandom_range(0, 11))
      0:  return -32768;
      1:  return 32767;
      2:  return base;
      3:  return clip16(base + set_band);
      4:  return clip16(base - set_band);
      5:  return clip16(base + set_band - 1);
      6:  return clip16(base - set_band + 1);
      7:  return clip16(base + lim);
      8:  return clip16(base - lim);
      9:  return clip16(base + lim + 1);
      10: return clip16(base - lim - 1);
      default: return clip16(set_radius - int'($urandom_range(0, 1)));
    endcase
  endfunction

  // mostly approach, lose and regain runs; the rest noise and edge values
  task automatic push_mix(input int n);
    int made, len, span, pick;
    made = 0;
    span = set_radius + 64;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) len = $urandom_range(4, 40);
      else if (pick < 70) len = $urandom_range(20, 45);
      else len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        if (pick < 40)
          push_tick(near(span), near(span), set_hover + near(600), $urandom_range(0, 19) != 0);
        else if (pick < 55)
          push_tick(rnd16(), rnd16(), rnd16(), 1'b0);
        else if (pick < 70)
          push_tick(near(4 * span), near(4 * span), rnd16(), 1'b1);
        else if (pick < 88)
          push_tick(rnd16(), rnd16(), rnd16(), 1'($urandom));
        else
          push_tick(edge_val(0, set_lim_xy), edge_val(0, set_lim_xy),
                    edge_val(set_hover, set_lim_z), 1'($urandom));
      end
      made += len;
    end
  endtask

  initial begin : stimulus
    lts_cfg_t plan[6];
    lts_cfg_t c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: field extremes, deadband and limit edges, radius edges
    push_tick(32767, -32768, 32767, 1'b1);
    push_tick(-32768, 32767, -32768, 1'b1);
    push_tick(0, 0, 300, 1'b1);
    push_tick(1, -1, 301, 1'b1);
    push_tick(66, -66, 234, 1'b1);
    push_tick(65, -65, 235, 1'b1);
    push_tick(3334, -3334, 3634, 1'b1);
    push_tick(3338, -3338, -3038, 1'b1);
    push_tick(199, 0, 0, 1'b1);
    push_tick(200, 0, 0, 1'b1);
    push_tick(0, -199, 300, 1'b1);
    push_tick(141, 141, 300, 1'b1);
    push_tick(142, -141, 300, 1'b1);
    push_tick(-5, 5, 300, 1'b0);
    push_tick(-32768, -32768, -32768, 1'b0);
    wait_idle();

    // unity gain, half gain with ties, saturating gain with zero limits, zero gain with
    // deadband over the limit, and a deadband above the horizontal limit
    plan[0] = '{16'd16384, 16'd16384, 15'd500, 15'd700, 15'd10, 15'd300, 16'sd0, 16'sd0};
    plan[1] = '{16'd8192, 16'd24576, 15'd32767, 15'd32767, 15'd0, 15'd32767,
                16'sh8000, 16'sh8000};
    plan[2] = '{16'd65535, 16'd65535, 15'd0, 15'd0, 15'd0, 15'd0, 16'sd32767, 16'sd32767};
    plan[3] = '{16'd0, 16'd0, 15'd1000, 15'd1000, 15'd32767, 15'd1000,
                16'sd32767, 16'sd32767};
    plan[4] = '{16'd4915, 16'd1234, 15'd300, 15'd2000, 15'd500, 15'd150, 16'sd100,
                -16'sd200};
    plan[5] = '{16'd16384, 16'd8193, 15'd32767, 15'd1, 15'd1, 15'd32767, -16'sd1,
                16'sd32767};
    foreach (plan[i]) begin
      program_set(plan[i]);
      push_mix(110);
      wait_idle();
    end
    repeat (2) begin
      c.gain_xy         = 16'($urandom_range(0, 65535));
      c.gain_z          = 16'($urandom_range(0, 65535));
      c.vel_limit_xy    = 15'($urandom_range(0, 32767));
      c.vel_limit_z     = 15'($urandom_range(0, 32767));
      c.dead_band       = 15'($urandom_range(0, 2000));
      c.land_radius     = 15'($urandom_range(0, 32767));
      c.land_height_max = 16'($urandom_range(0, 65535));
      c.hover_height    = 16'($urandom_range(0, 65535));
      program_set(c);
      push_mix(110);
      wait_idle();
    end

    // back to the reset settings for a mixed run
    program_set('{16'd4915, 16'd4915, 15'd1000, 15'd1000, 15'd20, 15'd200,
                  16'sd300, 16'sd300});
    push_mix(100);
    wait_idle();

    // landing: regain track, hold centred high until the count saturates, then descend
    program_set('{16'd4915, 16'd4915, 15'd1000, 15'd1000, 15'd20, 15'd400,
                  16'sd500, 16'sd0});
    guard_on = 1'b0;
    repeat (35) push_tick(500 + int'($urandom_range(0, 300)), near(100), 1000, 1'b1);
    repeat (70) push_tick(near(250), near(250), 600 + int'($urandom_range(0, 2000)), 1'b1);
    repeat (3) push_tick(near(250), near(250), int'($urandom_range(0, 500)), 1'b1);
    push_mix(20);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
